// ===== design/lpht_pkg.sv =====
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared widths, codes and types of the linear probing hash table.
// ----------------------------------------------------------------------------
`default_nettype none

package lpht_pkg;

   localparam int MAX_SLOTS_DEF = 32;
   localparam int KEY_BITS_DEF  = 16;

   localparam int ACT_W      = 2;
   localparam int STATUS_W   = 2;
   localparam int DAY_W      = 5;
   localparam int MONTH_W    = 4;
   localparam int YEAR_W     = 12;
   localparam int SALARY_W   = 32;
   localparam int TBL_W      = 6;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [TBL_W-1:0] TBL_RESET = 6'd23;
   localparam logic [31:0]      HASH_MUL  = 32'd2654435818;

   typedef logic [ACT_W-1:0] action_type;
   localparam action_type ACT_INSERT = 2'd0;
   localparam action_type ACT_LOOKUP = 2'd1;
   localparam action_type ACT_DELETE = 2'd2;

   typedef logic [STATUS_W-1:0] status_type;
   localparam status_type ST_INSERTED = 2'd0;
   localparam status_type ST_FOUND    = 2'd1;
   localparam status_type ST_MISSING  = 2'd2;
   localparam status_type ST_FULL     = 2'd3;

   // register index is byte address bit 2
   localparam logic REG_TABLE_SIZE = 1'b0;

   typedef struct packed {
      logic [DAY_W-1:0]    day;
      logic [MONTH_W-1:0]  month;
      logic [YEAR_W-1:0]   year;
      logic [SALARY_W-1:0] salary;
   } rec_type;

endpackage

`default_nettype wire

// ===== design/lpht_req_if.sv =====
// ----------------------------------------------------------------------------
// lpht_req_if
// Request channel: operation, key and record fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface lpht_req_if
   import lpht_pkg::*;
#(
   parameter int KEY_BITS = KEY_BITS_DEF
) ();

   logic                valid;
   logic                ready;
   logic [ACT_W-1:0]    action;
   logic [KEY_BITS-1:0] key;
   logic [DAY_W-1:0]    birth_day;
   logic [MONTH_W-1:0]  birth_month;
   logic [YEAR_W-1:0]   birth_year;
   logic [SALARY_W-1:0] salary;

   modport source (
      output valid, action, key, birth_day, birth_month, birth_year, salary,
      input  ready
   );

   modport sink (
      input  valid, action, key, birth_day, birth_month, birth_year, salary,
      output ready
   );

endinterface

`default_nettype wire

// ===== design/lpht_rsp_if.sv =====
// ----------------------------------------------------------------------------
// lpht_rsp_if
// Response channel: status, slot and stored record of the slot touched.
// ----------------------------------------------------------------------------
`default_nettype none

interface lpht_rsp_if
   import lpht_pkg::*;
#(
   parameter int MAX_SLOTS = MAX_SLOTS_DEF,
   parameter int KEY_BITS  = KEY_BITS_DEF
) ();

   localparam int SLOT_W = $clog2(MAX_SLOTS);
   localparam int CNT_W  = $clog2(MAX_SLOTS + 1);

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [SLOT_W-1:0]   slot;
   logic [KEY_BITS-1:0] found_key;
   logic [DAY_W-1:0]    found_day;
   logic [MONTH_W-1:0]  found_month;
   logic [YEAR_W-1:0]   found_year;
   logic [SALARY_W-1:0] found_salary;
   logic [CNT_W-1:0]    entry_total;

   modport source (
      output valid, status, slot, found_key, found_day, found_month, found_year,
             found_salary, entry_total,
      input  ready
   );

   modport sink (
      input  valid, status, slot, found_key, found_day, found_month, found_year,
             found_salary, entry_total,
      output ready
   );

endinterface

`default_nettype wire

// ===== design/linear_probe_hash_table_core.sv =====
// ----------------------------------------------------------------------------
// linear_probe_hash_table_core
// Open addressing hash table with multiplicative hash and linear probing.
// ----------------------------------------------------------------------------
// steps for a full table or unknown action: accept, two multiplier passes,
// result load; for a probe walk: accept, two multiplier passes, one slot per cycle,
// a registered check of each slot for lookup and delete, result load
// one item in flight; the next item is taken once the result is loaded
// reset clears used and tombstone flags, live count and table_size to 23
`default_nettype none

module linear_probe_hash_table_core
   import lpht_pkg::*;
#(
   parameter int MAX_SLOTS = MAX_SLOTS_DEF,
   parameter int KEY_BITS  = KEY_BITS_DEF
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   lpht_req_if.sink                   req_chan,
   lpht_rsp_if.source                 rsp_chan,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);

   localparam int SLOT_W = $clog2(MAX_SLOTS);
   localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
   localparam int REC_W  = $bits(rec_type);
   localparam int WORD_W = KEY_BITS + REC_W;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_HASH  = 3'd1;
   localparam logic [2:0] S_SCALE = 3'd2;
   localparam logic [2:0] S_PROBE = 3'd3;
   localparam logic [2:0] S_EMIT  = 3'd4;

   logic [2:0]          state_ff, state_in;
   logic [TBL_W-1:0]    tbl_ff;
   logic [CNT_W-1:0]    eff_size;

   action_type          act_ff, act_in;
   logic [KEY_BITS-1:0] key_ff, key_in;
   rec_type             rec_ff, rec_in;
   logic [31:0]         frac_ff, frac_in;
   logic [SLOT_W-1:0]   idx_ff, idx_in;
   logic [CNT_W-1:0]    tries_ff, tries_in;
   logic [MAX_SLOTS-1:0] used_ff, used_in;
   logic [MAX_SLOTS-1:0] tomb_ff, tomb_in;
   logic [CNT_W-1:0]    live_ff, live_in;

   logic                chk_vld_ff, chk_vld_in;
   logic [SLOT_W-1:0]   chk_idx_ff, chk_idx_in;
   logic                chk_used_ff, chk_used_in;
   logic                chk_tomb_ff, chk_tomb_in;
   logic                chk_last_ff, chk_last_in;

   status_type          res_status_ff, res_status_in;
   logic [SLOT_W-1:0]   res_slot_ff, res_slot_in;
   logic [KEY_BITS-1:0] res_key_ff, res_key_in;
   rec_type             res_rec_ff, res_rec_in;

   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic [KEY_BITS-1:0] rsp_key_ff, rsp_key_in;
   rec_type             rsp_rec_ff, rsp_rec_in;
   logic [CNT_W-1:0]    rsp_total_ff, rsp_total_in;

   logic [WORD_W-1:0]   mem [MAX_SLOTS];
   logic [WORD_W-1:0]   rd_ff;
   logic                mem_we;
   logic [KEY_BITS-1:0] rd_key;
   rec_type             rd_rec;

   logic [31:0]         mul_a, mul_b;
   logic [63:0]         prod;
   logic [SLOT_W:0]     idx_p1;
   logic [SLOT_W-1:0]   idx_inc;
   logic [CNT_W-1:0]    tries_p1;
   logic                out_free;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         tbl_ff <= TBL_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   (csr_paddr[2] == REG_TABLE_SIZE)) begin
         tbl_ff <= csr_pwdata[TBL_W-1:0];
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_TABLE_SIZE) ? CSR_DATA_W'(tbl_ff) : '0;

   always_comb begin
      if (tbl_ff == '0) begin
         eff_size = CNT_W'(1);
      end else if (int'(tbl_ff) > MAX_SLOTS) begin
         eff_size = CNT_W'(MAX_SLOTS);
      end else begin
         eff_size = CNT_W'(tbl_ff);
      end
   end

   // shared multiplier: key * HASH_MUL, then fraction * size
   assign mul_a = (state_ff == S_HASH) ? 32'(key_ff) : frac_ff;
   assign mul_b = (state_ff == S_HASH) ? HASH_MUL : 32'(eff_size);
   assign prod  = 64'(mul_a) * 64'(mul_b);

   assign idx_p1   = {1'b0, idx_ff} + 1'b1;
   assign idx_inc  = (idx_p1 == (SLOT_W + 1)'(eff_size)) ? '0 : idx_p1[SLOT_W-1:0];
   assign tries_p1 = tries_ff + CNT_W'(1);

   assign rd_key   = rd_ff[WORD_W-1 -: KEY_BITS];
   assign rd_rec   = rec_type'(rd_ff[REC_W-1:0]);
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      state_in      = state_ff;
      act_in        = act_ff;
      key_in        = key_ff;
      rec_in        = rec_ff;
      frac_in       = frac_ff;
      idx_in        = idx_ff;
      tries_in      = tries_ff;
      used_in       = used_ff;
      tomb_in       = tomb_ff;
      live_in       = live_ff;
      chk_vld_in    = 1'b0;
      chk_idx_in    = chk_idx_ff;
      chk_used_in   = chk_used_ff;
      chk_tomb_in   = chk_tomb_ff;
      chk_last_in   = chk_last_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_key_in    = res_key_ff;
      res_rec_in    = res_rec_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_key_in    = rsp_key_ff;
      rsp_rec_in    = rsp_rec_ff;
      rsp_total_in  = rsp_total_ff;
      mem_we        = 1'b0;
      req_chan.ready = 1'b0;

      case (state_ff)
         S_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               act_in        = req_chan.action;
               key_in        = req_chan.key;
               rec_in.day    = req_chan.birth_day;
               rec_in.month  = req_chan.birth_month;
               rec_in.year   = req_chan.birth_year;
               rec_in.salary = req_chan.salary;
               state_in      = S_HASH;
            end
         end
         S_HASH: begin
            frac_in  = prod[31:0];
            state_in = S_SCALE;
         end
         S_SCALE: begin
            idx_in        = prod[32 +: SLOT_W];
            tries_in      = '0;
            res_status_in = ST_MISSING;
            res_slot_in   = '0;
            res_key_in    = '0;
            res_rec_in    = '0;
            if (act_ff == ACT_INSERT) begin
               if (live_ff >= eff_size) begin
                  res_status_in = ST_FULL;
                  state_in      = S_EMIT;
               end else begin
                  state_in = S_PROBE;
               end
            end else if (act_ff == ACT_LOOKUP || act_ff == ACT_DELETE) begin
               state_in = S_PROBE;
            end else begin
               state_in = S_EMIT;
            end
         end
         S_PROBE: begin
            if (act_ff == ACT_INSERT) begin
               if (!used_ff[idx_ff]) begin
                  mem_we          = 1'b1;
                  used_in[idx_ff] = 1'b1;
                  tomb_in[idx_ff] = 1'b0;
                  live_in         = live_ff + CNT_W'(1);
                  res_status_in   = ST_INSERTED;
                  res_slot_in     = idx_ff;
                  res_key_in      = key_ff;
                  res_rec_in      = rec_ff;
                  state_in        = S_EMIT;
               end else if (tries_p1 == eff_size) begin
                  res_status_in = ST_FULL;
                  state_in      = S_EMIT;
               end else begin
                  idx_in   = idx_inc;
                  tries_in = tries_p1;
               end
            end else begin
               // issue one slot per cycle, check it in the next cycle
               if (tries_ff != eff_size) begin
                  chk_vld_in  = 1'b1;
                  chk_idx_in  = idx_ff;
                  chk_used_in = used_ff[idx_ff];
                  chk_tomb_in = tomb_ff[idx_ff];
                  chk_last_in = (tries_p1 == eff_size);
                  idx_in      = idx_inc;
                  tries_in    = tries_p1;
               end
               if (chk_vld_ff) begin
                  if (chk_used_ff && rd_key == key_ff) begin
                     res_status_in = ST_FOUND;
                     res_slot_in   = chk_idx_ff;
                     res_key_in    = rd_key;
                     res_rec_in    = rd_rec;
                     if (act_ff == ACT_DELETE) begin
                        used_in[chk_idx_ff] = 1'b0;
                        tomb_in[chk_idx_ff] = 1'b1;
                        if (live_ff != '0) begin
                           live_in = live_ff - CNT_W'(1);
                        end
                     end
                     chk_vld_in = 1'b0;
                     state_in   = S_EMIT;
                  end else if ((!chk_used_ff && !chk_tomb_ff) || chk_last_ff) begin
                     chk_vld_in = 1'b0;
                     state_in   = S_EMIT;
                  end
               end
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_slot_in   = res_slot_ff;
               rsp_key_in    = res_key_ff;
               rsp_rec_in    = res_rec_ff;
               rsp_total_in  = live_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         used_ff      <= '0;
         tomb_ff      <= '0;
         live_ff      <= '0;
         chk_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         tomb_ff      <= tomb_in;
         live_ff      <= live_in;
         chk_vld_ff   <= chk_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff        <= act_in;
      key_ff        <= key_in;
      rec_ff        <= rec_in;
      frac_ff       <= frac_in;
      idx_ff        <= idx_in;
      tries_ff      <= tries_in;
      chk_idx_ff    <= chk_idx_in;
      chk_used_ff   <= chk_used_in;
      chk_tomb_ff   <= chk_tomb_in;
      chk_last_ff   <= chk_last_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_key_ff    <= res_key_in;
      res_rec_ff    <= res_rec_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_rec_ff    <= rsp_rec_in;
      rsp_total_ff  <= rsp_total_in;
   end

   // slot storage: key and record, one port each for write and read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[idx_ff] <= {key_ff, rec_ff};
      end
      rd_ff <= mem[idx_ff];
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = rsp_status_ff;
   assign rsp_chan.slot         = rsp_slot_ff;
   assign rsp_chan.found_key    = rsp_key_ff;
   assign rsp_chan.found_day    = rsp_rec_ff.day;
   assign rsp_chan.found_month  = rsp_rec_ff.month;
   assign rsp_chan.found_year   = rsp_rec_ff.year;
   assign rsp_chan.found_salary = rsp_rec_ff.salary;
   assign rsp_chan.entry_total  = rsp_total_ff;

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      (used_ff & tomb_ff) == '0)
      else $error("slot both in use and tombstone");

   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      32'(live_ff) == $countones(used_ff))
      else $error("live count differs from slots in use");

   a_accept_starts_hash: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> state_ff == S_HASH)
      else $error("accepted item did not start hashing");

   a_probe_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_PROBE |-> CNT_W'(idx_ff) < eff_size)
      else $error("probe index beyond table size");

   a_result_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_EMIT)
      else $error("result raised outside emit");

endmodule

`default_nettype wire
